// ===== rtl/adsu_pkg.sv =====
// Shared types, constants and the micro-program of the advection-diffusion stencil unit.
// Used by the interfaces, divider, datapath, controller and top level.
// Depends on nothing.
package adsu_pkg;

	typedef logic signed [31:0] val_t;

	localparam val_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam val_t VAL_MIN = 32'sh8000_0000;

	// register indexes of the configuration port
	localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
	localparam logic [1:0] REG_TIME_STEP  = 2'd1;
	localparam logic [1:0] REG_VISCOSITY  = 2'd2;

	typedef struct packed {
		val_t       vel_x;
		val_t       vel_y;
		val_t       pos_x;
		val_t       pos_y;
		logic       is_fixed;
		val_t       fixed_vel_x;
		val_t       fixed_vel_y;
	} cell_t;

	typedef struct packed {
		logic [19:0] cell_index;
		val_t        new_vel_x;
		val_t        new_vel_y;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		OP_ADD, OP_SUB, OP_HALF, OP_MUL, OP_DIV, OP_LD, OP_OUTX, OP_OUTY
	} op_t;

	typedef enum logic [4:0] {
		LD_X_W, LD_Y_W, LD_X_WM1, LD_Y_WM1, LD_X_WP1, LD_Y_WP1, LD_X_2W, LD_Y_2W,
		LD_COL_P, LD_COL_M, LD_IN_PX, LD_IN_VX, LD_IN_VY, LD_RP0, LD_RP1, LD_RP2,
		LD_DT, LD_NU
	} ld_src_t;

	typedef logic [4:0] raddr_t;

	typedef struct packed {
		op_t     op;
		raddr_t  dst;
		raddr_t  a;
		raddr_t  b;
		ld_src_t src;
	} uop_t;

	typedef struct packed {
		logic accept;
		logic chk_rd;
		logic exec;
		logic wb;
		logic emit_int;
		logic emit_fix;
		uop_t uop;
	} dp_cmd_t;

	typedef struct packed {
		logic interior;
		logic fixed;
		logic div_busy;
		logic out_free;
	} dp_sts_t;

	typedef enum logic [2:0] {
		S_IDLE, S_CHKA, S_CHKB, S_FETCH, S_EXEC, S_WAIT, S_EMITI, S_EMITF
	} state_t;

	// register file slots
	localparam raddr_t R_XW   = 5'd0;
	localparam raddr_t R_YW   = 5'd1;
	localparam raddr_t R_XE   = 5'd2;
	localparam raddr_t R_YE   = 5'd3;
	localparam raddr_t R_XWW  = 5'd4;
	localparam raddr_t R_YWW  = 5'd5;
	localparam raddr_t R_XN   = 5'd6;
	localparam raddr_t R_YN   = 5'd7;
	localparam raddr_t R_XS   = 5'd8;
	localparam raddr_t R_YS   = 5'd9;
	localparam raddr_t R_CP   = 5'd10;
	localparam raddr_t R_CM   = 5'd11;
	localparam raddr_t R_CC   = 5'd12;
	localparam raddr_t R_RP0  = 5'd13;
	localparam raddr_t R_RP1  = 5'd14;
	localparam raddr_t R_RP2  = 5'd15;
	localparam raddr_t R_DT   = 5'd16;
	localparam raddr_t R_NU   = 5'd17;
	localparam raddr_t R_DXP  = 5'd18;
	localparam raddr_t R_DXM  = 5'd19;
	localparam raddr_t R_DYP  = 5'd20;
	localparam raddr_t R_DYM  = 5'd21;
	localparam raddr_t R_HX   = 5'd22;
	localparam raddr_t R_HY   = 5'd23;
	localparam raddr_t R_T1   = 5'd24;
	localparam raddr_t R_GXP  = 5'd25;
	localparam raddr_t R_GXM  = 5'd26;
	localparam raddr_t R_GYP  = 5'd27;
	localparam raddr_t R_GYM  = 5'd28;
	localparam raddr_t R_ADVX = 5'd29;
	localparam raddr_t R_ADVY = 5'd30;
	localparam raddr_t R_DXX  = 5'd31;
	localparam raddr_t R_DYY  = 5'd10; // column slot is free once spacings exist

	localparam int HEAD_LEN = 26;
	localparam int COMP_LEN = 25;
	localparam int PROG_LEN = HEAD_LEN + 2 * COMP_LEN;

	function automatic logic [31:0] mag(input val_t x);
		return x[31] ? 32'(-x) : 32'(x);
	endfunction

	// signed value from sign and magnitude, saturated to 32 bits
	function automatic val_t from_mag(input logic neg, input logic [47:0] m);
		if (!neg) begin
			return (m > 48'(VAL_MAX)) ? VAL_MAX : val_t'(m[31:0]);
		end
		return (m > 48'(VAL_MAX)) ? VAL_MIN : val_t'(-m[31:0]);
	endfunction

	function automatic uop_t mk(input op_t op, input raddr_t d, input raddr_t a,
			input raddr_t b, input ld_src_t s);
		return '{op: op, dst: d, a: a, b: b, src: s};
	endfunction

	function automatic uop_t ld(input raddr_t d, input ld_src_t s);
		return mk(OP_LD, d, d, d, s);
	endfunction

	function automatic uop_t head_op(input logic [4:0] k);
		case (k)
			5'd0:  return ld(R_XW, LD_X_W);
			5'd1:  return ld(R_YW, LD_Y_W);
			5'd2:  return ld(R_XE, LD_X_WM1);
			5'd3:  return ld(R_YE, LD_Y_WM1);
			5'd4:  return ld(R_XWW, LD_X_WP1);
			5'd5:  return ld(R_YWW, LD_Y_WP1);
			5'd6:  return ld(R_XN, LD_X_2W);
			5'd7:  return ld(R_YN, LD_Y_2W);
			5'd8:  return ld(R_XS, LD_IN_VX);
			5'd9:  return ld(R_YS, LD_IN_VY);
			5'd10: return ld(R_CP, LD_COL_P);
			5'd11: return ld(R_CM, LD_COL_M);
			5'd12: return ld(R_CC, LD_IN_PX);
			5'd13: return ld(R_RP0, LD_RP0);
			5'd14: return ld(R_RP1, LD_RP1);
			5'd15: return ld(R_RP2, LD_RP2);
			5'd16: return ld(R_DT, LD_DT);
			5'd17: return ld(R_NU, LD_NU);
			5'd18: return mk(OP_SUB, R_DXP, R_CP, R_CC, LD_DT);
			5'd19: return mk(OP_SUB, R_DXM, R_CC, R_CM, LD_DT);
			5'd20: return mk(OP_SUB, R_DYP, R_RP2, R_RP1, LD_DT);
			5'd21: return mk(OP_SUB, R_DYM, R_RP1, R_RP0, LD_DT);
			5'd22: return mk(OP_ADD, R_HX, R_DXP, R_DXM, LD_DT);
			5'd23: return mk(OP_HALF, R_HX, R_HX, R_HX, LD_DT);
			5'd24: return mk(OP_ADD, R_HY, R_DYP, R_DYM, LD_DT);
			default: return mk(OP_HALF, R_HY, R_HY, R_HY, LD_DT);
		endcase
	endfunction

	// one velocity component: q center, e/w/n/s neighbors, o output op
	function automatic uop_t comp_op(input logic [4:0] k, input raddr_t q, input raddr_t e,
			input raddr_t w, input raddr_t n, input raddr_t s, input op_t o);
		case (k)
			5'd0:  return mk(OP_SUB, R_T1, e, q, LD_DT);
			5'd1:  return mk(OP_DIV, R_GXP, R_T1, R_DXP, LD_DT);
			5'd2:  return mk(OP_SUB, R_T1, q, w, LD_DT);
			5'd3:  return mk(OP_DIV, R_GXM, R_T1, R_DXM, LD_DT);
			5'd4:  return mk(OP_SUB, R_T1, s, q, LD_DT);
			5'd5:  return mk(OP_DIV, R_GYP, R_T1, R_DYP, LD_DT);
			5'd6:  return mk(OP_SUB, R_T1, q, n, LD_DT);
			5'd7:  return mk(OP_DIV, R_GYM, R_T1, R_DYM, LD_DT);
			5'd8:  return mk(OP_ADD, R_T1, R_GXP, R_GXM, LD_DT);
			5'd9:  return mk(OP_MUL, R_T1, R_XW, R_T1, LD_DT);
			5'd10: return mk(OP_HALF, R_ADVX, R_T1, R_T1, LD_DT);
			5'd11: return mk(OP_ADD, R_T1, R_GYP, R_GYM, LD_DT);
			5'd12: return mk(OP_MUL, R_T1, R_YW, R_T1, LD_DT);
			5'd13: return mk(OP_HALF, R_ADVY, R_T1, R_T1, LD_DT);
			5'd14: return mk(OP_SUB, R_T1, R_GXP, R_GXM, LD_DT);
			5'd15: return mk(OP_DIV, R_DXX, R_T1, R_HX, LD_DT);
			5'd16: return mk(OP_SUB, R_T1, R_GYP, R_GYM, LD_DT);
			5'd17: return mk(OP_DIV, R_DYY, R_T1, R_HY, LD_DT);
			5'd18: return mk(OP_ADD, R_T1, R_DXX, R_DYY, LD_DT);
			5'd19: return mk(OP_MUL, R_T1, R_NU, R_T1, LD_DT);
			5'd20: return mk(OP_SUB, R_T1, R_T1, R_ADVX, LD_DT);
			5'd21: return mk(OP_SUB, R_T1, R_T1, R_ADVY, LD_DT);
			5'd22: return mk(OP_MUL, R_T1, R_DT, R_T1, LD_DT);
			5'd23: return mk(OP_ADD, R_T1, q, R_T1, LD_DT);
			default: return mk(o, R_T1, R_T1, R_T1, LD_DT);
		endcase
	endfunction

	function automatic uop_t prog_op(input logic [6:0] pc);
		if (32'(pc) < HEAD_LEN) begin
			return head_op(pc[4:0]);
		end
		if (32'(pc) < HEAD_LEN + COMP_LEN) begin
			return comp_op(5'(32'(pc) - HEAD_LEN), R_XW, R_XE, R_XWW, R_XN, R_XS, OP_OUTX);
		end
		return comp_op(5'(32'(pc) - HEAD_LEN - COMP_LEN), R_YW, R_YE, R_YWW, R_YN, R_YS,
			OP_OUTY);
	endfunction

endpackage

// ===== rtl/adsu_if.sv =====
// Valid/ready channel interfaces for cell requests and result requests.
// Depends on adsu_pkg.
interface adsu_cell_if;
	logic                valid;
	logic                ready;
	adsu_pkg::val_t      vel_x;
	adsu_pkg::val_t      vel_y;
	adsu_pkg::val_t      pos_x;
	adsu_pkg::val_t      pos_y;
	logic                is_fixed;
	adsu_pkg::val_t      fixed_vel_x;
	adsu_pkg::val_t      fixed_vel_y;

	modport source (output valid, vel_x, vel_y, pos_x, pos_y, is_fixed, fixed_vel_x,
		fixed_vel_y, input ready);
	modport sink (input valid, vel_x, vel_y, pos_x, pos_y, is_fixed, fixed_vel_x,
		fixed_vel_y, output ready);
endinterface

interface adsu_result_if;
	logic                valid;
	logic                ready;
	logic [19:0]         cell_index;
	adsu_pkg::val_t      new_vel_x;
	adsu_pkg::val_t      new_vel_y;
	logic                last;

	modport source (output valid, cell_index, new_vel_x, new_vel_y, last, input ready);
	modport sink (input valid, cell_index, new_vel_x, new_vel_y, last, output ready);
endinterface

// ===== rtl/explicit_advection_diffusion_stencil_unit.sv =====
// Top level of the explicit advection-diffusion stencil unit: APB registers,
// controller and datapath. Depends on adsu_pkg, adsu_if, adsu_ctrl, adsu_dp.
//
//   channel     dir  payload
//   cell_in     in   vel_x vel_y pos_x pos_y is_fixed fixed_vel_x fixed_vel_y
//   result_out  out  cell_index new_vel_x new_vel_y last
//   apb         in   grid_width @0, time_step @4, kinematic_viscosity @8
//
// A cell whose upper-row window entry is valid and not fixed runs a 76-step micro-program
// on one ALU, one 32x32 multiplier and a divider that yields one quotient bit a cycle,
// with twelve divides; when the cell is fixed too, its fixed velocity follows. Other
// cells emit only their fixed velocity when fixed, and nothing otherwise.
// Reset clears counters and the window fill count; no clearing pass is needed.
// A stalled result_out holds the controller in its emit state until the output frees.
module explicit_advection_diffusion_stencil_unit #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	adsu_cell_if.sink   cell_in,
	adsu_result_if.source result_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [10:0]       gw_q;
	logic [30:0]       dt_q;
	logic [30:0]       nu_q;
	adsu_pkg::dp_cmd_t cmd;
	adsu_pkg::dp_sts_t sts;
	adsu_pkg::cell_t   item;
	adsu_pkg::res_t    res;
	logic              in_ready;
	logic              out_valid;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q <= 11'd64;
			dt_q <= 31'd65;
			nu_q <= 31'd65536;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				adsu_pkg::REG_GRID_WIDTH: gw_q <= pwdata[10:0];
				adsu_pkg::REG_TIME_STEP:  dt_q <= pwdata[30:0];
				adsu_pkg::REG_VISCOSITY:  nu_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			adsu_pkg::REG_GRID_WIDTH: prdata = {21'd0, gw_q};
			adsu_pkg::REG_TIME_STEP:  prdata = {1'b0, dt_q};
			adsu_pkg::REG_VISCOSITY:  prdata = {1'b0, nu_q};
			default:                  prdata = '0;
		endcase
	end

	assign item = '{vel_x: cell_in.vel_x, vel_y: cell_in.vel_y, pos_x: cell_in.pos_x,
		pos_y: cell_in.pos_y, is_fixed: cell_in.is_fixed, fixed_vel_x: cell_in.fixed_vel_x,
		fixed_vel_y: cell_in.fixed_vel_y};
	assign cell_in.ready = in_ready;

	adsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cell_in.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	adsu_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item       (item),
		.grid_width (gw_q),
		.time_step  (dt_q),
		.viscosity  (nu_q),
		.out_ready  (result_out.ready),
		.out_valid  (out_valid),
		.out_item   (res)
	);

	assign result_out.valid      = out_valid;
	assign result_out.cell_index = res.cell_index;
	assign result_out.new_vel_x  = res.new_vel_x;
	assign result_out.new_vel_y  = res.new_vel_y;
	assign result_out.last       = res.last;
endmodule

// ===== rtl/adsu_div.sv =====
// Iterative restoring divider: (num * 2^16) / den, one quotient bit per cycle, saturated.
// Depends on adsu_pkg.
module adsu_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  adsu_pkg::val_t num,
	input  adsu_pkg::val_t den,
	output logic           busy,
	output adsu_pkg::val_t quo
);
	logic [47:0] n_q;
	logic [47:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        neg_q;
	logic        nz_q;
	logic        busy_q;
	logic [32:0] r_sh;
	logic        ge;

	assign r_sh = {r_q[31:0], n_q[47]};
	assign ge   = r_sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd47;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {adsu_pkg::mag(num), 16'd0};
			d_q   <= adsu_pkg::mag(den);
			r_q   <= '0;
			q_q   <= '0;
			neg_q <= num[31] ^ den[31];
			nz_q  <= num != '0;
		end else if (busy_q) begin
			n_q <= {n_q[46:0], 1'b0};
			r_q <= ge ? r_sh - {1'b0, d_q} : r_sh;
			q_q <= {q_q[46:0], ge};
		end
	end

	assign busy = busy_q;
	// a zero dividend gives zero, also over a zero divisor
	assign quo  = nz_q ? adsu_pkg::from_mag(neg_q, q_q) : '0;
endmodule

// ===== rtl/adsu_dp.sv =====
// Datapath: row window and column position memories, register file, ALU, multiplier,
// divider and result register. Depends on adsu_pkg and adsu_div.
module adsu_dp #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adsu_pkg::dp_cmd_t cmd,
	output adsu_pkg::dp_sts_t sts,
	input  adsu_pkg::cell_t   item,
	input  logic [10:0]       grid_width,
	input  logic [30:0]       time_step,
	input  logic [30:0]       viscosity,
	input  logic              out_ready,
	output logic              out_valid,
	output adsu_pkg::res_t    out_item
);
	localparam int DEPTH = 2 * MAX_WIDTH + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int FW    = $clog2(DEPTH + 1);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = $clog2(MAX_WIDTH);

	typedef struct packed {
		logic           fix;
		adsu_pkg::val_t x;
		adsu_pkg::val_t y;
	} win_t;

	win_t             win_mem [DEPTH];
	adsu_pkg::val_t   col_mem [MAX_WIDTH];
	adsu_pkg::val_t   rf [32];

	win_t             win_rd_q;
	logic             win_vld_q;
	adsu_pkg::val_t   col_rd_q;
	adsu_pkg::val_t   ra_q, rb_q;
	adsu_pkg::cell_t  item_q;
	adsu_pkg::val_t   rp0_q, rp1_q, rp2_q;
	adsu_pkg::val_t   nx_q, ny_q;
	logic [WW-1:0]    w_q;
	logic [CW-1:0]    col_q, c_q;
	logic [19:0]      cell_q, cidx_q;
	logic [AW-1:0]    wp_q;
	logic [FW-1:0]    fill_q;
	logic [63:0]      prod_s1;
	logic             mneg_s1;
	logic             out_valid_q;
	adsu_pkg::res_t   out_q;

	logic [WW-1:0]    w_eff;
	logic [CW-1:0]    c_now, c_nxt, cp, cm, cidx;
	logic [AW-1:0]    wp_n, waddr;
	int               age;
	logic             wvld;
	adsu_pkg::uop_t   u;
	adsu_pkg::val_t   alu, ldv, wd, mul_res, div_res;
	logic             we;
	logic             div_busy;

	function automatic adsu_pkg::val_t sat_sum(input logic [32:0] s);
		if (s[32] != s[31]) begin
			return s[32] ? adsu_pkg::VAL_MIN : adsu_pkg::VAL_MAX;
		end
		return adsu_pkg::val_t'(s[31:0]);
	endfunction

	assign u = cmd.uop;

	always_comb begin
		if (grid_width < 11'd3) begin
			w_eff = WW'(3);
		end else if (32'(grid_width) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(grid_width);
		end
		c_now = (32'(col_q) >= 32'(w_eff)) ? '0 : col_q;
		c_nxt = (32'(c_now) + 1 >= 32'(w_eff)) ? '0 : c_now + 1'b1;
		cp    = (32'(c_q) + 1 >= 32'(w_q)) ? '0 : c_q + 1'b1;
		cm    = (c_q == '0) ? CW'(32'(w_q) - 1) : c_q - 1'b1;
		wp_n  = (32'(wp_q) == DEPTH - 1) ? '0 : wp_q + 1'b1;
	end

	// window tap: age of the entry relative to the newest cell
	always_comb begin
		age = 32'(w_q);
		if (!cmd.chk_rd) begin
			case (u.src)
				adsu_pkg::LD_X_WM1, adsu_pkg::LD_Y_WM1: age = 32'(w_q) - 1;
				adsu_pkg::LD_X_WP1, adsu_pkg::LD_Y_WP1: age = 32'(w_q) + 1;
				adsu_pkg::LD_X_2W, adsu_pkg::LD_Y_2W:   age = 2 * 32'(w_q);
				default:                                age = 32'(w_q);
			endcase
		end
		waddr = (32'(wp_q) >= age) ? AW'(32'(wp_q) - age) : AW'(32'(wp_q) + DEPTH - age);
		wvld  = age < 32'(fill_q);
		cidx  = (u.src == adsu_pkg::LD_COL_M) ? cm : cp;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			win_mem[wp_n]  <= '{fix: item.is_fixed, x: item.vel_x, y: item.vel_y};
			col_mem[c_now] <= item.pos_x;
		end
		win_rd_q <= win_mem[waddr];
		col_rd_q <= col_mem[cidx];
		if (we) begin
			rf[u.dst] <= wd;
		end
		ra_q <= rf[u.a];
		rb_q <= rf[u.b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= 1'b0;
			wp_q      <= AW'(DEPTH - 1);
			fill_q    <= '0;
			col_q     <= '0;
			cell_q    <= '0;
			rp0_q     <= '0;
			rp1_q     <= '0;
			rp2_q     <= '0;
		end else begin
			win_vld_q <= wvld;
			if (cmd.accept) begin
				wp_q   <= wp_n;
				fill_q <= (32'(fill_q) == DEPTH) ? fill_q : fill_q + 1'b1;
				col_q  <= c_nxt;
				cell_q <= cell_q + 20'd1;
				if (c_now == '0) begin
					rp0_q <= rp1_q;
					rp1_q <= rp2_q;
				end
				rp2_q <= item.pos_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q <= item;
			w_q    <= w_eff;
			c_q    <= c_now;
			cidx_q <= cell_q;
		end
		if (cmd.exec && u.op == adsu_pkg::OP_MUL) begin
			prod_s1 <= adsu_pkg::mag(ra_q) * adsu_pkg::mag(rb_q);
			mneg_s1 <= ra_q[31] ^ rb_q[31];
		end
		if (cmd.exec && u.op == adsu_pkg::OP_OUTX) begin
			nx_q <= ra_q;
		end
		if (cmd.exec && u.op == adsu_pkg::OP_OUTY) begin
			ny_q <= ra_q;
		end
	end

	adsu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.exec && u.op == adsu_pkg::OP_DIV),
		.num    (ra_q),
		.den    (rb_q),
		.busy   (div_busy),
		.quo    (div_res)
	);

	assign mul_res = adsu_pkg::from_mag(mneg_s1, prod_s1[63:16]);

	always_comb begin
		case (u.src)
			adsu_pkg::LD_X_W, adsu_pkg::LD_X_WM1, adsu_pkg::LD_X_WP1, adsu_pkg::LD_X_2W:
				ldv = win_vld_q ? win_rd_q.x : '0;
			adsu_pkg::LD_Y_W, adsu_pkg::LD_Y_WM1, adsu_pkg::LD_Y_WP1, adsu_pkg::LD_Y_2W:
				ldv = win_vld_q ? win_rd_q.y : '0;
			adsu_pkg::LD_COL_P, adsu_pkg::LD_COL_M: ldv = col_rd_q;
			adsu_pkg::LD_IN_PX: ldv = item_q.pos_x;
			adsu_pkg::LD_IN_VX: ldv = item_q.vel_x;
			adsu_pkg::LD_IN_VY: ldv = item_q.vel_y;
			adsu_pkg::LD_RP0:   ldv = rp0_q;
			adsu_pkg::LD_RP1:   ldv = rp1_q;
			adsu_pkg::LD_RP2:   ldv = rp2_q;
			adsu_pkg::LD_DT:    ldv = {1'b0, time_step};
			adsu_pkg::LD_NU:    ldv = {1'b0, viscosity};
			default:            ldv = '0;
		endcase
		case (u.op)
			adsu_pkg::OP_ADD:  alu = sat_sum({ra_q[31], ra_q} + {rb_q[31], rb_q});
			adsu_pkg::OP_SUB:  alu = sat_sum({ra_q[31], ra_q} - {rb_q[31], rb_q});
			adsu_pkg::OP_HALF: alu = (ra_q + (ra_q[31] ? 32'sd1 : 32'sd0)) >>> 1;
			default:           alu = ldv;
		endcase
		we = cmd.wb || (cmd.exec && (u.op == adsu_pkg::OP_ADD || u.op == adsu_pkg::OP_SUB ||
			u.op == adsu_pkg::OP_HALF || u.op == adsu_pkg::OP_LD));
		if (cmd.wb) begin
			wd = (u.op == adsu_pkg::OP_MUL) ? mul_res : div_res;
		end else begin
			wd = alu;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_int || cmd.emit_fix) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_int) begin
			out_q <= '{cell_index: cidx_q - 20'(w_q), new_vel_x: nx_q, new_vel_y: ny_q,
				last: !item_q.is_fixed};
		end else if (cmd.emit_fix) begin
			out_q <= '{cell_index: cidx_q, new_vel_x: item_q.fixed_vel_x,
				new_vel_y: item_q.fixed_vel_y, last: 1'b1};
		end
	end

	assign sts.interior = win_vld_q && !win_rd_q.fix;
	assign sts.fixed    = item_q.is_fixed;
	assign sts.div_busy = div_busy;
	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign out_item     = out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= DEPTH) else $error("window fill count past depth");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && u.op == adsu_pkg::OP_DIV) |-> !div_busy)
		else $error("divide started while divider busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(out_q)))
		else $error("stalled result request changed");
endmodule

// ===== rtl/adsu_ctrl.sv =====
// Controller: sequences accept, interior check, micro-program and result emission.
// Depends on adsu_pkg.
module adsu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  adsu_pkg::dp_sts_t sts,
	output adsu_pkg::dp_cmd_t cmd
);
	adsu_pkg::state_t state_q, state_d;
	logic [6:0]       pc_q, pc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= adsu_pkg::S_IDLE;
			pc_q    <= '0;
		end else begin
			state_q <= state_d;
			pc_q    <= pc_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		cmd      = '0;
		cmd.uop  = adsu_pkg::prog_op(pc_q);
		in_ready = 1'b0;
		case (state_q)
			adsu_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = adsu_pkg::S_CHKA;
				end
			end
			adsu_pkg::S_CHKA: begin
				cmd.chk_rd = 1'b1;
				state_d    = adsu_pkg::S_CHKB;
			end
			adsu_pkg::S_CHKB: begin
				pc_d = '0;
				if (sts.interior) begin
					state_d = adsu_pkg::S_FETCH;
				end else if (sts.fixed) begin
					state_d = adsu_pkg::S_EMITF;
				end else begin
					state_d = adsu_pkg::S_IDLE;
				end
			end
			adsu_pkg::S_FETCH: begin
				state_d = adsu_pkg::S_EXEC;
			end
			adsu_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				if (cmd.uop.op == adsu_pkg::OP_MUL || cmd.uop.op == adsu_pkg::OP_DIV) begin
					state_d = adsu_pkg::S_WAIT;
				end else if (32'(pc_q) == adsu_pkg::PROG_LEN - 1) begin
					state_d = adsu_pkg::S_EMITI;
				end else begin
					pc_d    = pc_q + 7'd1;
					state_d = adsu_pkg::S_FETCH;
				end
			end
			adsu_pkg::S_WAIT: begin
				// on a divide, hold until the divider drains; a multiply does not wait
				if (!(cmd.uop.op == adsu_pkg::OP_DIV && sts.div_busy)) begin
					cmd.wb = 1'b1;
					if (32'(pc_q) == adsu_pkg::PROG_LEN - 1) begin
						state_d = adsu_pkg::S_EMITI;
					end else begin
						pc_d    = pc_q + 7'd1;
						state_d = adsu_pkg::S_FETCH;
					end
				end
			end
			adsu_pkg::S_EMITI: begin
				if (sts.out_free) begin
					cmd.emit_int = 1'b1;
					state_d      = sts.fixed ? adsu_pkg::S_EMITF : adsu_pkg::S_IDLE;
				end
			end
			adsu_pkg::S_EMITF: begin
				if (sts.out_free) begin
					cmd.emit_fix = 1'b1;
					state_d      = adsu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = adsu_pkg::S_IDLE;
			end
		endcase
	end

	a_fetch_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == adsu_pkg::S_FETCH |=> state_q == adsu_pkg::S_EXEC)
		else $error("fetch not followed by execute");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_int || cmd.emit_fix) |-> sts.out_free)
		else $error("result loaded over a pending request");
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pc_q) < adsu_pkg::PROG_LEN) else $error("program counter out of range");
	a_accept_chk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == adsu_pkg::S_CHKA)
		else $error("accepted cell not checked");
endmodule
